// ----- rtl/core/dual_slot_commit_controller_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the dual slot commit controller
// Property forms used by the dscc_engine RTL file of the block.
// ----------------------------------------------------------------------------
`ifndef DUAL_SLOT_COMMIT_CONTROLLER_ASSERT_SVH
`define DUAL_SLOT_COMMIT_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DSCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/dscc_pkg.sv -----
// ----------------------------------------------------------------------------
// dscc_pkg
// Types and constants shared by the dual slot commit controller modules.
// ----------------------------------------------------------------------------
package dscc_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD       = 2'd0,
    CMD_MARK_DIRTY = 2'd1,
    CMD_TICK       = 2'd2,
    CMD_WRITE_DONE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_LOADED   = 3'd1,
    ST_DEFAULTS = 3'd2,
    ST_REQUEST  = 3'd3,
    ST_SAVED    = 3'd4,
    ST_RETRY    = 3'd5
  } status_e;

  localparam logic [15:0] SAVE_DELAY_RESET = 16'd1000;
  localparam logic        SLOT_A           = 1'b0;

  typedef struct packed {
    cmd_e        command;
    logic [31:0] now_ms;
    logic        slot_a_valid;
    logic [31:0] slot_a_generation;
    logic        slot_b_valid;
    logic [31:0] slot_b_generation;
    logic        write_ok;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic        slot;
    logic [31:0] generation_out;
  } result_t;

endpackage

// ----- rtl/core/dual_slot_commit_controller.sv -----
// ----------------------------------------------------------------------------
// dual_slot_commit_controller
// A/B ping-pong commit control for one saved record.
//
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid_i/tready_o     tuser command, tdata slot info
// m_axis    out        m_axis_tvalid_o/tready_i     tuser status, tdata slot, gen
// cfg       in         cfg_valid_i/cfg_ready_o      cfg_data_i save delay in ms
//
// Every event beat produces exactly one result beat, registered in the input
// register and then the result register. One event is accepted per cycle
// while m_axis takes every result beat; each register holds one beat.
// A stall on m_axis fills the result register, then the input register,
// and only then drops s_axis_tready_o. The configuration port is always ready.
// Reset clears all commit state and sets the save delay to 1000 ms.
// ----------------------------------------------------------------------------
module dual_slot_commit_controller
  import dscc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [31:0] now_ms, [32] slot_a_valid, [64:33] slot_a_generation,
  // [65] slot_b_valid, [97:66] slot_b_generation, [98] write_ok, [103:99] zero
  input  logic [103:0] s_axis_tdata_i,
  // [1:0] command
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [0] slot, [32:1] generation_out, [39:33] zero
  output logic [39:0]  m_axis_tdata_o,
  // [2:0] status
  output logic [2:0]   m_axis_tuser_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [15:0]  cfg_data_i
);

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    out_ready;
  logic    fire;
  result_t res;
  result_t out_res;

  assign in_item.command           = cmd_e'(s_axis_tuser_i);
  assign in_item.now_ms            = s_axis_tdata_i[31:0];
  assign in_item.slot_a_valid      = s_axis_tdata_i[32];
  assign in_item.slot_a_generation = s_axis_tdata_i[64:33];
  assign in_item.slot_b_valid      = s_axis_tdata_i[65];
  assign in_item.slot_b_generation = s_axis_tdata_i[97:66];
  assign in_item.write_ok          = s_axis_tdata_i[98];

  assign fire        = held_valid && out_ready;
  assign cfg_ready_o = 1'b1;

  dscc_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (in_item),
    .valid_o (held_valid),
    .take_i  (fire),
    .item_o  (held_item)
  );

  dscc_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .item_i     (held_item),
    .res_o      (res)
  );

  dscc_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (held_valid),
    .ready_o (out_ready),
    .res_i   (res),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (out_res)
  );

  assign m_axis_tuser_o = out_res.status;
  assign m_axis_tdata_o = {7'd0, out_res.generation_out, out_res.slot};

endmodule

// ----- rtl/core/dscc_in_stage.sv -----
// ----------------------------------------------------------------------------
// dscc_in_stage
// Input register: captures one event beat and holds it until it is processed.
// ----------------------------------------------------------------------------
module dscc_in_stage
  import dscc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  take_i,
  output item_t item_o
);

  logic  valid_q;
  logic  valid_d;
  item_t item_q;
  logic  load;

  assign ready_o = !valid_q || take_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- rtl/core/dscc_engine.sv -----
// ----------------------------------------------------------------------------
// dscc_engine
// Commit state and the single-pass event logic for load, dirty, tick and done.
// ----------------------------------------------------------------------------
`include "dual_slot_commit_controller_assert.svh"

module dscc_engine
  import dscc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic        fire_i,
  input  item_t       item_i,
  output result_t     res_o
);

  logic [15:0] delay_q;
  logic [31:0] gen_q, gen_d;
  logic [31:0] deadline_q, deadline_d;
  logic        active_q, active_d;
  logic        has_q, has_d;
  logic        dirty_q, dirty_d;
  logic        pend_q, pend_d;
  logic        chg_q, chg_d;

  logic [31:0] gen_diff;
  logic [31:0] time_diff;
  logic [31:0] retry_time;
  logic [31:0] gen_inc;
  logic        b_newer;
  logic        pick_b;
  logic        reached;
  logic        target;
  result_t     res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= SAVE_DELAY_RESET;
    end else if (cfg_we_i) begin
      delay_q <= cfg_data_i;
    end
  end

  assign gen_diff   = item_i.slot_b_generation - item_i.slot_a_generation;
  assign b_newer    = (gen_diff != 32'd0) && !gen_diff[31];
  assign pick_b     = item_i.slot_b_valid && (!item_i.slot_a_valid || b_newer);
  // The deadline is reached when now minus deadline lies in the lower half range.
  assign time_diff  = item_i.now_ms - deadline_q;
  assign reached    = !time_diff[31];
  assign retry_time = item_i.now_ms + {16'd0, delay_q};
  assign gen_inc    = gen_q + 32'd1;
  assign target     = has_q ? !active_q : SLOT_A;

  always_comb begin
    gen_d      = gen_q;
    deadline_d = deadline_q;
    active_d   = active_q;
    has_d      = has_q;
    dirty_d    = dirty_q;
    pend_d     = pend_q;
    chg_d      = chg_q;
    res.status         = ST_IDLE;
    res.slot           = active_q;
    res.generation_out = gen_q;
    unique case (item_i.command)
      CMD_LOAD: begin
        pend_d = 1'b0;
        chg_d  = 1'b0;
        if (pick_b || item_i.slot_a_valid) begin
          gen_d      = pick_b ? item_i.slot_b_generation : item_i.slot_a_generation;
          deadline_d = item_i.now_ms;
          active_d   = pick_b;
          has_d      = 1'b1;
          dirty_d    = 1'b0;
          res.status         = ST_LOADED;
          res.slot           = pick_b;
          res.generation_out = gen_d;
        end else begin
          gen_d      = 32'd0;
          deadline_d = retry_time;
          active_d   = SLOT_A;
          has_d      = 1'b0;
          dirty_d    = 1'b1;
          res.status         = ST_DEFAULTS;
          res.slot           = SLOT_A;
          res.generation_out = 32'd0;
        end
      end
      CMD_MARK_DIRTY: begin
        dirty_d    = 1'b1;
        deadline_d = retry_time;
        if (pend_q) begin
          chg_d = 1'b1;
        end
      end
      CMD_TICK: begin
        if (dirty_q && !pend_q && reached) begin
          pend_d = 1'b1;
          chg_d  = 1'b0;
          res.status         = ST_REQUEST;
          res.slot           = target;
          res.generation_out = gen_inc;
        end
      end
      CMD_WRITE_DONE: begin
        if (pend_q) begin
          pend_d = 1'b0;
          chg_d  = 1'b0;
          res.slot = target;
          if (item_i.write_ok) begin
            gen_d    = gen_inc;
            active_d = target;
            has_d    = 1'b1;
            // A change that arrived during the write keeps the record dirty.
            dirty_d  = chg_q;
            res.status         = ST_SAVED;
            res.generation_out = gen_inc;
          end else begin
            deadline_d = retry_time;
            res.status = ST_RETRY;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q      <= 32'd0;
      deadline_q <= 32'd0;
      active_q   <= SLOT_A;
      has_q      <= 1'b0;
      dirty_q    <= 1'b0;
      pend_q     <= 1'b0;
      chg_q      <= 1'b0;
    end else if (fire_i) begin
      gen_q      <= gen_d;
      deadline_q <= deadline_d;
      active_q   <= active_d;
      has_q      <= has_d;
      dirty_q    <= dirty_d;
      pend_q     <= pend_d;
      chg_q      <= chg_d;
    end
  end

  assign res_o = res;

  `DSCC_ASSERT_IMP(a_chg_needs_pend, clk_i, rst_ni, chg_q, pend_q, "change flag without pending write")
  `DSCC_ASSERT_NXT(a_req_sets_pend, clk_i, rst_ni, fire_i && (res.status == ST_REQUEST), pend_q, "write request did not set pending")
  `DSCC_ASSERT_NXT(a_save_bumps_gen, clk_i, rst_ni, fire_i && (res.status == ST_SAVED), (gen_q == $past(gen_inc)) && !pend_q, "save did not advance generation")

endmodule

// ----- rtl/core/dscc_out_stage.sv -----
// ----------------------------------------------------------------------------
// dscc_out_stage
// Result register: holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module dscc_out_stage
  import dscc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  result_t res_i,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  logic    valid_q;
  logic    valid_d;
  result_t res_q;
  logic    load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ----- tb/dscc_commit_checker.sv -----
// ----------------------------------------------------------------------------
// dscc_commit_checker
// Watches the event, result and configuration channels of the dual slot
// commit controller, predicts the result of every accepted event beat and
// compares it, field by field, with the result beats in order.
// ----------------------------------------------------------------------------
module dscc_commit_checker
  import dscc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_i,
  // [31:0] now_ms, [32] slot_a_valid, [64:33] slot_a_generation,
  // [65] slot_b_valid, [97:66] slot_b_generation, [98] write_ok, [103:99] zero
  input  logic [103:0] s_axis_tdata_i,
  // [1:0] command
  input  logic [1:0]   s_axis_tuser_i,
  input  logic         m_axis_tvalid_i,
  input  logic         m_axis_tready_i,
  // [0] slot, [32:1] generation_out, [39:33] zero
  input  logic [39:0]  m_axis_tdata_i,
  // [2:0] status
  input  logic [2:0]   m_axis_tuser_i,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [15:0]  cfg_data_i,
  output int           mismatch_count_o,
  output int           results_outstanding_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] HALF_SPAN = 32'h8000_0000;

  // Shadow of the controller's commit state and its one register.
  logic [15:0] delay_ms;
  logic [31:0] cur_gen;
  logic [31:0] deadline;
  logic        act_slot;
  logic        has_rec;
  logic        is_dirty;
  logic        wr_pending;
  logic        changed_in_write;

  result_t expected_results[$];
  int      mismatches;

  function automatic logic gen_ahead(input logic [31:0] cand, input logic [31:0] base);
    logic [31:0] diff;
    diff = cand - base;
    return (diff != 32'd0) && (diff < HALF_SPAN);
  endfunction

  function automatic logic [31:0] deadline_from(input logic [31:0] now);
    return now + {16'd0, delay_ms};
  endfunction

  function automatic logic save_target();
    return has_rec ? ~act_slot : SLOT_A;
  endfunction

  function automatic result_t commit_step(input item_t ev);
    result_t res;
    logic    pick_b;
    res.status = ST_IDLE;
    res.slot = act_slot;
    res.generation_out = cur_gen;
    case (ev.command)
      CMD_LOAD: begin
        pick_b = ev.slot_b_valid &&
                 (!ev.slot_a_valid || gen_ahead(ev.slot_b_generation, ev.slot_a_generation));
        wr_pending = 1'b0;
        changed_in_write = 1'b0;
        if (pick_b || ev.slot_a_valid) begin
          cur_gen = pick_b ? ev.slot_b_generation : ev.slot_a_generation;
          deadline = ev.now_ms;
          act_slot = pick_b;
          has_rec = 1'b1;
          is_dirty = 1'b0;
          res.status = ST_LOADED;
          res.slot = act_slot;
          res.generation_out = cur_gen;
        end else begin
          cur_gen = 32'd0;
          deadline = deadline_from(ev.now_ms);
          act_slot = SLOT_A;
          has_rec = 1'b0;
          is_dirty = 1'b1;
          res.status = ST_DEFAULTS;
          res.slot = SLOT_A;
          res.generation_out = 32'd0;
        end
      end
      CMD_MARK_DIRTY: begin
        is_dirty = 1'b1;
        deadline = deadline_from(ev.now_ms);
        if (wr_pending) changed_in_write = 1'b1;
      end
      CMD_TICK: begin
        if (is_dirty && !wr_pending && ((ev.now_ms - deadline) < HALF_SPAN)) begin
          wr_pending = 1'b1;
          changed_in_write = 1'b0;
          res.status = ST_REQUEST;
          res.slot = save_target();
          res.generation_out = cur_gen + 32'd1;
        end
      end
      default: begin
        // A write-done beat with no write outstanding leaves everything alone.
        if (wr_pending) begin
          wr_pending = 1'b0;
          res.slot = save_target();
          if (ev.write_ok) begin
            cur_gen = cur_gen + 32'd1;
            act_slot = res.slot;
            has_rec = 1'b1;
            is_dirty = changed_in_write;
            res.status = ST_SAVED;
          end else begin
            deadline = deadline_from(ev.now_ms);
            res.status = ST_RETRY;
          end
          changed_in_write = 1'b0;
          res.generation_out = cur_gen;
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    item_t   ev;
    result_t got;
    result_t want;
    if (!rst_ni) begin
      delay_ms = SAVE_DELAY_RESET;
      cur_gen = 32'd0;
      deadline = 32'd0;
      act_slot = SLOT_A;
      has_rec = 1'b0;
      is_dirty = 1'b0;
      wr_pending = 1'b0;
      changed_in_write = 1'b0;
      expected_results.delete();
      mismatches = 0;
      mismatch_count_o <= 0;
      results_outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) delay_ms = cfg_data_i;

      if (s_axis_tvalid_i && s_axis_tready_i) begin
        ev.command = cmd_e'(s_axis_tuser_i);
        ev.now_ms = s_axis_tdata_i[31:0];
        ev.slot_a_valid = s_axis_tdata_i[32];
        ev.slot_a_generation = s_axis_tdata_i[64:33];
        ev.slot_b_valid = s_axis_tdata_i[65];
        ev.slot_b_generation = s_axis_tdata_i[97:66];
        ev.write_ok = s_axis_tdata_i[98];
        expected_results.push_back(commit_step(ev));
      end

      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.status = status_e'(m_axis_tuser_i);
        got.slot = m_axis_tdata_i[0];
        got.generation_out = m_axis_tdata_i[32:1];
        if (expected_results.size() == 0) begin
          $error("result beat with no event awaiting it: status %0d slot %0d generation %0h",
                 got.status, got.slot, got.generation_out);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
          end
          if (got.slot != want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, got.slot);
            mismatches++;
          end
          if (got.generation_out != want.generation_out) begin
            $error("generation_out: expected %0h, got %0h",
                   want.generation_out, got.generation_out);
            mismatches++;
          end
        end
      end

      mismatch_count_o <= mismatches;
      results_outstanding_o <= expected_results.size();
    end
  end

endmodule

// ----- tb/tb_dual_slot_commit_controller.sv -----
// ----------------------------------------------------------------------------
// tb_dual_slot_commit_controller
// Drives the dual slot commit controller with a directed run of load, save,
// retry and wraparound cases, then with random event streams under several
// save delays and handshake idling patterns, and reports the verdict of the
// commit checker.
// ----------------------------------------------------------------------------
module tb_dual_slot_commit_controller;

  import dscc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEGMENT_EVENTS = 240;
  localparam int STALL_LIMIT    = 2000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [103:0] s_axis_tdata_i = '0;
  logic [1:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [39:0]  m_axis_tdata_o;
  logic [2:0]   m_axis_tuser_o;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [15:0]  cfg_data_i = '0;

  int          mismatch_count;
  int          results_outstanding;
  int          send_idle_pct = 16;
  int          recv_idle_pct = 69;
  int          quiet_cycles = 0;
  logic [15:0] cur_delay = SAVE_DELAY_RESET;
  logic [31:0] sim_ms = 32'd0;

  dual_slot_commit_controller dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  dscc_commit_checker checker_i (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .s_axis_tvalid_i       (s_axis_tvalid_i),
    .s_axis_tready_i       (s_axis_tready_o),
    .s_axis_tdata_i        (s_axis_tdata_i),
    .s_axis_tuser_i        (s_axis_tuser_i),
    .m_axis_tvalid_i       (m_axis_tvalid_o),
    .m_axis_tready_i       (m_axis_tready_i),
    .m_axis_tdata_i        (m_axis_tdata_o),
    .m_axis_tuser_i        (m_axis_tuser_o),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_i           (cfg_ready_o),
    .cfg_data_i            (cfg_data_i),
    .mismatch_count_o      (mismatch_count),
    .results_outstanding_o (results_outstanding)
  );

  initial begin
    forever #5ns clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Ends a run that has stopped moving on any channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic item_t mk_event(input cmd_e cmd, input logic [31:0] now,
                                     input logic av, input logic [31:0] ag,
                                     input logic bv, input logic [31:0] bg,
                                     input logic ok);
    item_t ev;
    ev.command = cmd;
    ev.now_ms = now;
    ev.slot_a_valid = av;
    ev.slot_a_generation = ag;
    ev.slot_b_valid = bv;
    ev.slot_b_generation = bg;
    ev.write_ok = ok;
    return ev;
  endfunction

  function automatic logic [31:0] corner_generation();
    case ($urandom_range(4))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Mostly a plausible save cycle: marks, ticks that step past the deadline,
  // and write completions, with loads and wild time jumps mixed in.
  function automatic item_t random_event();
    item_t ev;
    int    pick;
    ev.slot_a_valid = 1'($urandom_range(1));
    ev.slot_a_generation = $urandom();
    ev.slot_b_valid = 1'($urandom_range(1));
    ev.slot_b_generation = $urandom();
    ev.write_ok = ($urandom_range(99) < 75);
    pick = $urandom_range(99);
    if (pick < 6) begin
      ev.command = CMD_LOAD;
      sim_ms = sim_ms + $urandom_range(0, 20);
      ev.slot_a_valid = ($urandom_range(99) < 80);
      ev.slot_b_valid = ($urandom_range(99) < 80);
      if ($urandom_range(3) == 0) ev.slot_a_generation = corner_generation();
      case ($urandom_range(3))
        0: ev.slot_b_generation = ev.slot_a_generation + $urandom_range(0, 8) - 4;
        1: ev.slot_b_generation = ev.slot_a_generation + 32'h8000_0000 + $urandom_range(0, 2) - 1;
        default: ev.slot_b_generation = $urandom();
      endcase
    end else if (pick < 26) begin
      ev.command = CMD_MARK_DIRTY;
      sim_ms = sim_ms + $urandom_range(0, 50);
    end else if (pick < 70) begin
      ev.command = CMD_TICK;
      case ($urandom_range(9))
        0, 1, 2, 3: sim_ms = sim_ms + cur_delay + $urandom_range(0, 3);
        4, 5, 6, 7: sim_ms = sim_ms + $urandom_range(0, cur_delay / 8 + 1);
        8: sim_ms = $urandom();
        default: ;
      endcase
    end else begin
      ev.command = CMD_WRITE_DONE;
      sim_ms = sim_ms + $urandom_range(0, 20);
    end
    ev.now_ms = sim_ms;
    return ev;
  endfunction

  task automatic send_event(input item_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= ev.command;
    s_axis_tdata_i <= {5'd0, ev.write_ok, ev.slot_b_generation, ev.slot_b_valid,
                       ev.slot_a_generation, ev.slot_a_valid, ev.now_ms};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Holds the sender back until every result is out, then lets the
  // input and result registers settle.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (results_outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_save_delay(input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_delay = value;
  endtask

  initial begin
    logic [15:0] delay_choice;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset save delay of 1000 ms.
    send_event(mk_event(CMD_WRITE_DONE, 32'd0, 1'b0, 32'd0, 1'b0, 32'd0, 1'b1));
    send_event(mk_event(CMD_TICK, 32'd0, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));
    send_event(mk_event(CMD_MARK_DIRTY, 32'd0, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));
    send_event(mk_event(CMD_TICK, 32'd999, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));
    send_event(mk_event(CMD_TICK, 32'd1000, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));
    send_event(mk_event(CMD_TICK, 32'd1001, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));
    send_event(mk_event(CMD_MARK_DIRTY, 32'd1002, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));
    send_event(mk_event(CMD_WRITE_DONE, 32'd1003, 1'b0, 32'd0, 1'b0, 32'd0, 1'b1));
    send_event(mk_event(CMD_TICK, 32'd2002, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));
    send_event(mk_event(CMD_WRITE_DONE, 32'd2005, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));
    send_event(mk_event(CMD_TICK, 32'd3005, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));
    send_event(mk_event(CMD_WRITE_DONE, 32'd3006, 1'b0, 32'd0, 1'b0, 32'd0, 1'b1));
    send_event(mk_event(CMD_TICK, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));
    // Neither slot valid, with a deadline that wraps past zero.
    send_event(mk_event(CMD_LOAD, 32'hFFFF_FF00, 1'b0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF,
                        1'b1));
    send_event(mk_event(CMD_TICK, 32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));
    send_event(mk_event(CMD_TICK, 32'h0000_02E8, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));
    // A load abandons the write just requested; generation 0 is newer than all ones.
    send_event(mk_event(CMD_LOAD, 32'h10, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0));
    send_event(mk_event(CMD_WRITE_DONE, 32'h11, 1'b0, 32'd0, 1'b0, 32'd0, 1'b1));
    send_event(mk_event(CMD_LOAD, 32'h12, 1'b1, 32'd5, 1'b1, 32'd5, 1'b0));
    send_event(mk_event(CMD_LOAD, 32'h13, 1'b1, 32'd0, 1'b1, 32'h8000_0000, 1'b0));
    send_event(mk_event(CMD_LOAD, 32'h14, 1'b1, 32'h8000_0001, 1'b1, 32'd0, 1'b0));
    send_event(mk_event(CMD_LOAD, 32'h15, 1'b0, 32'd0, 1'b1, 32'h1234_5678, 1'b0));
    send_event(mk_event(CMD_LOAD, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF,
                        1'b1));
    // Exactly half the time range past the deadline does not count as reached.
    send_event(mk_event(CMD_MARK_DIRTY, 32'd0, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));
    send_event(mk_event(CMD_TICK, 32'h8000_03E8, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));
    send_event(mk_event(CMD_TICK, 32'h8000_03E7, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));
    send_event(mk_event(CMD_WRITE_DONE, 32'd0, 1'b0, 32'd0, 1'b0, 32'd0, 1'b0));

    for (int seg = 0; seg < 6; seg++) begin
      drain_results();
      case (seg)
        0: delay_choice = 16'd0;
        1: delay_choice = 16'hFFFF;
        2: delay_choice = 16'($urandom_range(1, 40));
        3: delay_choice = 16'($urandom_range(0, 65535));
        4: delay_choice = 16'd1;
        default: delay_choice = 16'($urandom_range(100, 5000));
      endcase
      write_save_delay(delay_choice);
      if (seg >= 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (seg >= 2) begin
        send_idle_pct = 69;
        recv_idle_pct = 16;
      end
      for (int n = 0; n < SEGMENT_EVENTS; n++) send_event(random_event());
    end

    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (results_outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0 && results_outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
